// ----- hw/rtl/b58d_pkg.sv -----
// Shared constants, types and the alphabet lookup for the Base58 decoder.
package b58d_pkg;

  localparam int MAX_CHARS  = 64;
  localparam int ACC_BYTES  = 48;
  localparam int RESULT_CAP = 64;
  localparam int RADIX      = 58;

  localparam int ACC_AW  = (ACC_BYTES > 1) ? $clog2(ACC_BYTES) : 1;
  localparam int USED_W  = $clog2(ACC_BYTES + 1);
  localparam int CNT_W   = $clog2(MAX_CHARS + 2);
  localparam int ZC_W    = 7;
  localparam int NOUT_W  = $clog2(RESULT_CAP + 1);
  localparam int CARRY_W = 6;
  localparam int SUM_W   = 8 + CARRY_W;
  localparam int OFF_W   = 9;

  localparam logic [ZC_W-1:0] ZC_MAX = '1;
  localparam logic [7:0] CHAR_ONE = 8'h31;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [CARRY_W-1:0] digit;
  } digit_t;

  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t r;
    r.valid = 1'b1;
    r.digit = '0;
    if (c inside {[8'h31:8'h39]}) begin
      r.digit = CARRY_W'(c - 8'h31);
    end else if (c inside {[8'h41:8'h48]}) begin
      r.digit = CARRY_W'(c - 8'h41 + 8'd9);
    end else if (c inside {[8'h4A:8'h4E]}) begin
      r.digit = CARRY_W'(c - 8'h4A + 8'd17);
    end else if (c inside {[8'h50:8'h5A]}) begin
      r.digit = CARRY_W'(c - 8'h50 + 8'd22);
    end else if (c inside {[8'h61:8'h6B]}) begin
      r.digit = CARRY_W'(c - 8'h61 + 8'd33);
    end else if (c inside {[8'h6D:8'h7A]}) begin
      r.digit = CARRY_W'(c - 8'h6D + 8'd44);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/b58d_ram.sv -----
// Single-write, single-read memory with registered read data.
module b58d_ram #(
  parameter int DEPTH = 48,
  parameter int WIDTH = 8,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/b58d_mac.sv -----
// Multiply-by-58 and add-carry step applied to one accumulator byte.
module b58d_mac (
  input  logic [7:0]                  byte_i,
  input  logic [b58d_pkg::CARRY_W-1:0] carry_i,
  output logic [7:0]                  byte_o,
  output logic [b58d_pkg::CARRY_W-1:0] carry_o
);
  import b58d_pkg::*;

  logic [SUM_W-1:0] sum;

  assign sum     = SUM_W'(byte_i) * SUM_W'(RADIX) + SUM_W'(carry_i);
  assign byte_o  = sum[7:0];
  assign carry_o = sum[SUM_W-1:8];

endmodule

// ----- hw/rtl/base58_decoder.sv -----
// Base58 decoder top level: input control, fold sequencer and byte output.
// A '1' in the leading run, a bad character or any character after an error stays in S_IDLE;
// any other character goes through S_PRIME, then S_FOLD walks the accumulator bytes
// (up to 48) one per cycle through the shared multiply-by-58 unit and the memory port.
// After the last character: S_FINISH, then S_EMIT_RD and S_EMIT_WR per output word (error: 1 word).
// Reset (rst_ni low, async) clears control state; the accumulator memory is not reset.
module base58_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic       m_axis_tlast_o,
  output logic [1:0] m_axis_tuser_o    // [1:0] status
);
  import b58d_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PRIME   = 3'd1;
  localparam logic [2:0] S_FOLD    = 3'd2;
  localparam logic [2:0] S_FINISH  = 3'd3;
  localparam logic [2:0] S_ERR_OUT = 3'd4;
  localparam logic [2:0] S_EMIT_RD = 3'd5;
  localparam logic [2:0] S_EMIT_WR = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [USED_W-1:0]  j_q, j_d;
  logic [CARRY_W-1:0] carry_q, carry_d;
  logic [ZC_W-1:0]    zc_q, zc_d;
  logic [CNT_W-1:0]   cc_q, cc_d;
  logic               prefix_q, prefix_d;
  logic [1:0]         err_q, err_d;
  logic               last_q, last_d;
  logic [NOUT_W-1:0]  n_q, n_d;
  logic [NOUT_W-1:0]  ntot_q, ntot_d;

  logic       out_vld_q, out_vld_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_last_q, out_last_d;
  logic [1:0] out_stat_q, out_stat_d;

  logic               in_acc;
  logic               out_free;
  digit_t             dig;
  logic               ram_we;
  logic [ACC_AW-1:0]  ram_waddr;
  logic [ACC_AW-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;
  logic [7:0]         mac_in;
  logic [7:0]         mac_byte;
  logic [CARRY_W-1:0] mac_carry;
  logic               fold_done;
  logic               too_long;
  logic [7:0]         tot;
  logic [OFF_W-1:0]   emit_off;
  logic               emit_zero;
  logic               emit_last;

  b58d_ram #(
    .DEPTH(ACC_BYTES),
    .WIDTH(8),
    .AW   (ACC_AW)
  ) u_acc (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(mac_byte),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  b58d_mac u_mac (
    .byte_i (mac_in),
    .carry_i(carry_q),
    .byte_o (mac_byte),
    .carry_o(mac_carry)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign dig             = digit_of(s_axis_tdata_i);

  assign mac_in    = (j_q < used_q) ? ram_rdata : 8'd0;
  assign fold_done = (carry_q == '0 && j_q >= used_q) || (j_q == USED_W'(ACC_BYTES));
  assign ram_waddr = ACC_AW'(USED_W'(ACC_BYTES - 1) - j_q);
  assign ram_we    = (state_q == S_FOLD) && !fold_done;

  assign too_long  = cc_q > CNT_W'(MAX_CHARS);
  assign tot       = 8'(zc_q) + 8'(used_q);
  assign emit_off  = OFF_W'(ACC_BYTES) - OFF_W'(used_q) + OFF_W'(n_q) - OFF_W'(zc_q);
  assign emit_zero = (OFF_W'(n_q) < OFF_W'(zc_q)) || (used_q == '0);
  assign emit_last = (n_q + NOUT_W'(1)) == ntot_q;

  always_comb begin
    case (state_q)
      S_PRIME:   ram_raddr = ACC_AW'(ACC_BYTES - 1);
      S_FOLD:    ram_raddr = ACC_AW'(USED_W'(ACC_BYTES - 2) - j_q);
      S_EMIT_RD: ram_raddr = emit_off[ACC_AW-1:0];
      S_EMIT_WR: ram_raddr = emit_off[ACC_AW-1:0];
      default:   ram_raddr = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    j_d        = j_q;
    carry_d    = carry_q;
    zc_d       = zc_q;
    cc_d       = cc_q;
    prefix_d   = prefix_q;
    err_d      = err_q;
    last_d     = last_q;
    n_d        = n_q;
    ntot_d     = ntot_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    out_stat_d = out_stat_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_d = s_axis_tlast_i;
          if (cc_q <= CNT_W'(MAX_CHARS)) begin
            cc_d = cc_q + CNT_W'(1);
          end
          state_d = s_axis_tlast_i ? S_FINISH : S_IDLE;
          if (err_q == ST_OK) begin
            if (prefix_q && s_axis_tdata_i == CHAR_ONE) begin
              if (zc_q != ZC_MAX) begin
                zc_d = zc_q + ZC_W'(1);
              end
            end else begin
              prefix_d = 1'b0;
              if (!dig.valid) begin
                err_d = ST_BAD_CHAR;
              end else begin
                carry_d = dig.digit;
                j_d     = '0;
                state_d = S_PRIME;
              end
            end
          end
        end
      end
      S_PRIME: begin
        state_d = S_FOLD;
      end
      S_FOLD: begin
        if (fold_done) begin
          used_d = j_q;
          if (carry_q != '0 && err_q == ST_OK) begin
            err_d = ST_TOO_LONG;
          end
          state_d = last_q ? S_FINISH : S_IDLE;
        end else begin
          carry_d = mac_carry;
          j_d     = j_q + USED_W'(1);
        end
      end
      S_FINISH: begin
        n_d = '0;
        if (tot == 8'd0) begin
          ntot_d = NOUT_W'(1);
        end else if (tot > 8'(RESULT_CAP)) begin
          ntot_d = NOUT_W'(RESULT_CAP);
        end else begin
          ntot_d = NOUT_W'(tot);
        end
        state_d = (too_long || err_q != ST_OK) ? S_ERR_OUT : S_EMIT_RD;
      end
      S_ERR_OUT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = 8'd0;
          out_last_d = 1'b1;
          out_stat_d = too_long ? ST_TOO_LONG : err_q;
          state_d    = S_IDLE;
          used_d     = '0;
          zc_d       = '0;
          cc_d       = '0;
          prefix_d   = 1'b1;
          err_d      = ST_OK;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = emit_zero ? 8'd0 : ram_rdata;
          out_last_d = emit_last;
          out_stat_d = ST_OK;
          n_d        = n_q + NOUT_W'(1);
          if (emit_last) begin
            state_d  = S_IDLE;
            used_d   = '0;
            zc_d     = '0;
            cc_d     = '0;
            prefix_d = 1'b1;
            err_d    = ST_OK;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      zc_q      <= '0;
      cc_q      <= '0;
      prefix_q  <= 1'b1;
      err_q     <= ST_OK;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      zc_q      <= zc_d;
      cc_q      <= cc_d;
      prefix_q  <= prefix_d;
      err_q     <= err_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q        <= j_d;
    carry_q    <= carry_d;
    last_q     <= last_d;
    n_q        <= n_d;
    ntot_q     <= ntot_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_stat_q <= out_stat_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_stat_q;

endmodule

// ----- tb/tb_base58_decoder.sv -----
// Self-checking testbench for the streaming Base58 decoder, with scoreboard and drivers.
module tb_base58_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import b58d_pkg::*;

  localparam string ALPHABET = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  localparam int    CYCLE_LIMIT = 400000;
  localparam int    TOTAL_WORDS = 360;
  localparam int    LONG_HOLD = 1500;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  class b58_scoreboard;
    out_word_t   expected_q[$];
    bit [7:0]    acc[ACC_BYTES];
    int unsigned used_bytes;
    int unsigned zero_run;
    int unsigned char_count;
    bit          in_prefix;
    logic [1:0]  err;
    int unsigned n_chars;
    int unsigned n_strings;
    int unsigned n_bad;
    int unsigned n_long;
    int unsigned n_checked;
    int unsigned errors;

    function new();
      n_chars = 0;
      n_strings = 0;
      n_bad = 0;
      n_long = 0;
      n_checked = 0;
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (acc[i]) acc[i] = 8'd0;
      used_bytes = 0;
      zero_run = 0;
      char_count = 0;
      in_prefix = 1'b1;
      err = ST_OK;
    endfunction

    function int digit_value(logic [7:0] ch);
      for (int i = 0; i < RADIX; i++) begin
        if (ALPHABET[i] == ch) return i;
      end
      return -1;
    endfunction

    // multiply by the radix and add, walking the bytes in use and any further bytes the carry reaches
    function void fold_digit(int unsigned digit);
      int unsigned carry;
      int unsigned j;
      int unsigned k;
      carry = digit;
      for (j = 0; j < ACC_BYTES; j++) begin
        k = ACC_BYTES - 1 - j;
        if (carry == 0 && j >= used_bytes) break;
        carry += acc[k] * 32'd58;
        acc[k] = carry[7:0];
        carry = carry >> 8;
      end
      used_bytes = j;
      if (carry != 0 && err == ST_OK) err = ST_TOO_LONG;
    endfunction

    function void note_char(logic [7:0] ch, logic last);
      int        digit;
      int        first;
      int        total;
      int        pos;
      out_word_t w;
      n_chars++;
      if (char_count <= MAX_CHARS) char_count++;
      if (err == ST_OK) begin
        if (in_prefix && ch == CHAR_ONE) begin
          if (zero_run < 127) zero_run++;
        end else begin
          in_prefix = 1'b0;
          digit = digit_value(ch);
          if (digit < 0) err = ST_BAD_CHAR;
          else fold_digit(digit);
        end
      end
      if (!last) return;
      n_strings++;
      if (char_count > MAX_CHARS || err != ST_OK) begin
        w.data = 8'd0;
        w.last = 1'b1;
        w.status = (char_count > MAX_CHARS) ? ST_TOO_LONG : err;
        if (w.status == ST_TOO_LONG) n_long++;
        else n_bad++;
        expected_q.push_back(w);
        clear_string();
        return;
      end
      first = 0;
      while (first < ACC_BYTES && acc[first] == 8'd0) first++;
      total = zero_run + (ACC_BYTES - first);
      if (total > RESULT_CAP) total = RESULT_CAP;
      if (total == 0) total = 1;
      for (int idx = 0; idx < total; idx++) begin
        pos = first + idx - int'(zero_run);
        w.data = (idx < zero_run || pos >= ACC_BYTES) ? 8'd0 : acc[pos];
        w.last = (idx == total - 1);
        w.status = ST_OK;
        expected_q.push_back(w);
      end
      clear_string();
    endfunction

    function void check_result(logic [7:0] data, logic last, logic [1:0] status);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected word: data_byte %0h last_byte %0b status %0d", data, last, status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (data !== e.data) begin
        $error("data_byte: expected %0h, actual %0h", e.data, data);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_byte: expected %0b, actual %0b", e.last, last);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;

  b58_scoreboard sb = new();
  char_word_t    stim_q[$];
  bit            quiet = 1'b0;
  int unsigned   cycle_count = 0;

  base58_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_axis_tready_o) sb.note_char(s_tdata, s_tlast);
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      sb.check_result(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, sb.expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void push_word(logic [7:0] ch, logic last);
    char_word_t w;
    w.ch = ch;
    w.last = last;
    stim_q.push_back(w);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] ch;
    ch = $urandom_range(0, 255);
    while (sb.digit_value(ch) >= 0) ch = $urandom_range(0, 255);
    return ch;
  endfunction

  // fill of zero means random alphabet characters
  function automatic void push_string(int len, int ones, int bad_pos, logic [7:0] fill);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      if (i == bad_pos) ch = bad_char();
      else if (i < ones) ch = CHAR_ONE;
      else if (fill != 8'd0) ch = fill;
      else ch = ALPHABET[$urandom_range(0, RADIX - 1)];
      push_word(ch, i == len - 1);
    end
  endfunction

  function automatic void push_noise(int len);
    for (int i = 0; i < len; i++) push_word($urandom_range(0, 255), i == len - 1);
  endfunction

  function automatic void build_stimulus();
    int kind;
    int len;
    int ones;
    int bad;
    push_text("1");
    push_text("z");
    push_text("2");
    push_text("21");
    push_text("11z");
    push_text("1z1");
    push_word(8'h80, 1'b1);
    push_word(8'hFF, 1'b1);
    push_word(8'h00, 1'b1);
    push_text("0");
    push_text("O");
    push_text("I");
    push_text("l");
    push_text("z0a");
    push_string(MAX_CHARS, MAX_CHARS, -1, 8'd0);
    push_string(MAX_CHARS, 0, -1, "z");
    push_string(MAX_CHARS + 1, 0, 3, 8'd0);
    while (stim_q.size() < TOTAL_WORDS) begin
      kind = $urandom_range(0, 99);
      len = (kind < 5) ? $urandom_range(40, MAX_CHARS) : $urandom_range(1, 12);
      ones = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      bad = (kind >= 70 && kind < 88) ? $urandom_range(0, len - 1) : -1;
      if (kind >= 88 && kind < 91) len = $urandom_range(MAX_CHARS + 1, MAX_CHARS + 6);
      if (kind >= 91) push_noise(len);
      else push_string(len, ones, bad, 8'd0);
    end
  endfunction

  initial begin
    int  stall_left;
    bit  idle_on;
    bit  held;
    stall_left = 0;
    idle_on = 1'b1;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if ((cycle_count % 64) == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!held && sb.n_chars >= 160) begin
        held = 1'b1;
        stall_left = LONG_HOLD;
      end else if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      m_tready <= (stall_left == 0);
    end
  end

  initial begin
    bit idle_on;
    int drain;
    idle_on = 1'b0;
    build_stimulus();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (stim_q[i]) begin
      if (i >= (stim_q.size() * 85) / 100) quiet = 1'b1;
      if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      s_tvalid <= 1'b1;
      s_tdata <= stim_q[i].ch;
      s_tlast <= stim_q[i].last;
      do @(posedge clk_i); while (!s_axis_tready_o);
      if (stim_q[i].last) idle_on = ($urandom_range(0, 3) != 0);
    end
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    // allow a stray extra word to show up
    for (drain = 0; drain < 200; drain++) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $error("words missing: expected %0d more, actual 0", sb.expected_q.size());
      sb.errors++;
    end
    $display("%0d chars in %0d strings (%0d bad character, %0d too long), %0d words checked",
             sb.n_chars, sb.n_strings, sb.n_bad, sb.n_long, sb.n_checked);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/b58d_pkg.sv
hw/rtl/b58d_ram.sv
hw/rtl/b58d_mac.sv
hw/rtl/base58_decoder.sv
tb/tb_base58_decoder.sv
